// ----- hw/rtl/eflux_pkg.sv -----
`timescale 1ns / 1ps

package eflux_pkg;

  // Number format
  localparam int VALUE_W = 32;
  localparam int FRAC_W  = 16;
  localparam int QUO_W   = VALUE_W + FRAC_W;
  localparam int GM1_W   = 18;
  localparam logic [GM1_W-1:0] GM1_RESET = 18'd26214;

  localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // Request kinds
  localparam logic [1:0] REQ_FLUX_PRIM    = 2'd0;
  localparam logic [1:0] REQ_FLUX_CONS    = 2'd1;
  localparam logic [1:0] REQ_PRIM_TO_CONS = 2'd2;
  localparam logic [1:0] REQ_CONS_TO_PRIM = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DENSITY = 2'd1;
  localparam logic [1:0] ST_SAT     = 2'd2;

  // Register addresses
  localparam logic [1:0] ADDR_GM1 = 2'd0;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [30:0]        density;
    logic signed [31:0] second_value;
    logic signed [31:0] third_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_first;
    logic signed [31:0] out_second;
    logic signed [31:0] out_third;
    logic [1:0]         status;
  } out_item_t;

  // Operands that ride along with the divider
  typedef struct packed {
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] rho;
    logic signed [VALUE_W-1:0] v2;
    logic signed [VALUE_W-1:0] v3;
  } ctx_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] val;
    logic                      sat;
  } sval_t;

  function automatic logic [VALUE_W-1:0] mag(input logic signed [VALUE_W-1:0] x);
    return x[VALUE_W-1] ? VALUE_W'(-x) : VALUE_W'(x);
  endfunction

  // Round a magnitude product to nearest, halves away from zero, and saturate
  function automatic sval_t rnd_sat(input logic neg, input logic [2*VALUE_W-1:0] prod);
    logic [2*VALUE_W:0]        t;
    logic [2*VALUE_W-FRAC_W:0] s;
    logic [VALUE_W-1:0]        lim;
    sval_t                     r;
    t   = {1'b0, prod} + ((2*VALUE_W+1)'(1) << (FRAC_W - 1));
    s   = t[2*VALUE_W:FRAC_W];
    lim = neg ? VALUE_W'(VMIN) : VALUE_W'(VMAX);
    r.sat = s > (2*VALUE_W-FRAC_W+1)'(lim);
    if (r.sat) begin
      s = (2*VALUE_W-FRAC_W+1)'(lim);
    end
    r.val = neg ? -$signed(s[VALUE_W-1:0]) : $signed(s[VALUE_W-1:0]);
    return r;
  endfunction

  function automatic sval_t add_sat(input logic signed [VALUE_W-1:0] a,
                                    input logic signed [VALUE_W-1:0] b);
    logic signed [VALUE_W:0] s;
    sval_t                   r;
    s     = (VALUE_W+1)'(a) + (VALUE_W+1)'(b);
    r.sat = s[VALUE_W] != s[VALUE_W-1];
    r.val = r.sat ? (s[VALUE_W] ? VMIN : VMAX) : s[VALUE_W-1:0];
    return r;
  endfunction

  function automatic sval_t sub_sat(input logic signed [VALUE_W-1:0] a,
                                    input logic signed [VALUE_W-1:0] b);
    logic signed [VALUE_W:0] s;
    sval_t                   r;
    s     = (VALUE_W+1)'(a) - (VALUE_W+1)'(b);
    r.sat = s[VALUE_W] != s[VALUE_W-1];
    r.val = r.sat ? (s[VALUE_W] ? VMIN : VMAX) : s[VALUE_W-1:0];
    return r;
  endfunction

  // Multiply by one half with rounding away from zero; never saturates
  function automatic logic signed [VALUE_W-1:0] half_q(input logic signed [VALUE_W-1:0] x);
    logic [VALUE_W:0]   m;
    logic [VALUE_W-1:0] h;
    m = {1'b0, mag(x)} + (VALUE_W+1)'(1);
    h = m[VALUE_W:1];
    return x[VALUE_W-1] ? -$signed(h) : $signed(h);
  endfunction

endpackage

// ----- hw/rtl/eflux_mul.sv -----
`timescale 1ns / 1ps

module eflux_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [eflux_pkg::VALUE_W-1:0] a,
  input  logic signed [eflux_pkg::VALUE_W-1:0] b,
  output logic [2*eflux_pkg::VALUE_W-1:0]      prod,
  output logic                                 neg
);

  // Register magnitude product and sign; rounding happens in the next stage
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= (2*eflux_pkg::VALUE_W)'(eflux_pkg::mag(a)) *
              (2*eflux_pkg::VALUE_W)'(eflux_pkg::mag(b));
      neg  <= a[eflux_pkg::VALUE_W-1] ^ b[eflux_pkg::VALUE_W-1];
    end
  end

endmodule

// ----- hw/rtl/eflux_div.sv -----
`timescale 1ns / 1ps

module eflux_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [eflux_pkg::VALUE_W-1:0] a,
  input  logic [eflux_pkg::VALUE_W-1:0]        b,
  input  eflux_pkg::ctx_t                      in_ctx,
  output logic                                 out_valid,
  output logic signed [eflux_pkg::VALUE_W-1:0] q,
  output logic                                 sat,
  output eflux_pkg::ctx_t                      out_ctx
);

  localparam int VW = eflux_pkg::VALUE_W;
  localparam int QW = eflux_pkg::QUO_W;

  typedef struct packed {
    logic [VW-1:0]   rem;
    logic [QW-1:0]   quo;
    logic [QW-1:0]   num;
    logic [VW-1:0]   ub;
    logic            aneg;
    logic            az;
    eflux_pkg::ctx_t ctx;
  } dstage_t;

  dstage_t       stg [0:QW];
  dstage_t       nxt [0:QW];
  logic [QW:0]   vld;

  // Load the scaled dividend magnitude
  always_comb begin
    nxt[0].rem  = '0;
    nxt[0].quo  = '0;
    nxt[0].num  = {eflux_pkg::mag(a), {eflux_pkg::FRAC_W{1'b0}}};
    nxt[0].ub   = b;
    nxt[0].aneg = a[VW-1];
    nxt[0].az   = a == '0;
    nxt[0].ctx  = in_ctx;
  end

  // One restoring quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [VW:0] rs;
    logic        ge;
    always_comb begin
      rs = {stg[k-1].rem, stg[k-1].num[QW-1]};
      ge = rs >= {1'b0, stg[k-1].ub};
      nxt[k]      = stg[k-1];
      nxt[k].rem  = ge ? VW'(rs - {1'b0, stg[k-1].ub}) : rs[VW-1:0];
      nxt[k].quo  = {stg[k-1].quo[QW-2:0], ge};
      nxt[k].num  = stg[k-1].num << 1;
    end
  end

  for (genvar k = 0; k <= QW; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en) begin
        stg[k] <= nxt[k];
      end
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[QW-1:0], in_valid};
      out_valid <= vld[QW];
    end
  end

  // Round the quotient, then saturate; a zero divisor saturates with the dividend sign unless the dividend is zero
  logic                 rnd;
  logic [QW:0]          qr;
  logic [QW:0]          lim;
  logic signed [VW-1:0] q_next;
  logic                 sat_next;

  always_comb begin
    rnd = stg[QW].rem >= (stg[QW].ub - stg[QW].rem);
    qr  = {1'b0, stg[QW].quo} + (QW+1)'(rnd);
    lim = stg[QW].aneg ? (QW+1)'(eflux_pkg::mag(eflux_pkg::VMIN))
                       : (QW+1)'(eflux_pkg::VMAX);
    priority if (stg[QW].ub == '0) begin
      sat_next = !stg[QW].az;
      q_next   = stg[QW].az ? '0 : (stg[QW].aneg ? eflux_pkg::VMIN : eflux_pkg::VMAX);
    end else if (qr > lim) begin
      sat_next = 1'b1;
      q_next   = stg[QW].aneg ? eflux_pkg::VMIN : eflux_pkg::VMAX;
    end else begin
      sat_next = 1'b0;
      q_next   = stg[QW].aneg ? -$signed(qr[VW-1:0]) : $signed(qr[VW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q       <= q_next;
      sat     <= sat_next;
      out_ctx <= stg[QW].ctx;
    end
  end

endmodule

// ----- hw/rtl/eflux_obuf.sv -----
`timescale 1ns / 1ps

module eflux_obuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  eflux_pkg::out_item_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_ready,
  output eflux_pkg::out_item_t out_data
);

  logic                 tail_valid;
  eflux_pkg::out_item_t tail;
  logic                 pop;

  assign pop  = out_valid && out_ready;
  assign full = out_valid && tail_valid;

  // Two-entry output queue: head drives the port, tail catches a result under stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      tail_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= tail_valid || push;
      tail_valid <= tail_valid && push;
    end else if (push) begin
      tail_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= tail_valid ? tail : push_data;
      if (tail_valid) begin
        tail <= push_data;
      end
    end else if (push) begin
      tail <= push_data;
    end
  end

endmodule

// ----- hw/rtl/euler_flux_ideal_gas_1d.sv -----
`timescale 1ns / 1ps

// One-dimensional ideal-gas Euler flux and state conversion in signed Q16.16.
// A transaction carries a request kind (flux from primitives, flux from
// conservatives, primitives to conservatives, conservatives to primitives)
// and three values; the block answers each with one result and a status
// (ok, density not positive, saturated). One transaction is taken every
// cycle unless the input stalls; a result reaches the output port through
// 60 register stages, of which 50 are the radix-2 divider (load,
// 48 quotient-bit stages, rounding), nine carry the four pipelined
// multiply/round pairs and the adds, and one is the output queue head.
// A two-entry output queue lets new transactions enter while a result
// waits; the input stalls only while a result is held and the queue is full.
// gamma - 1 sits at byte address 0 of the register port and must be written
// only while the block is idle.
module euler_flux_ideal_gas_1d (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  eflux_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output eflux_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int VW = eflux_pkg::VALUE_W;

  typedef struct packed {
    logic [1:0]           kind;
    logic signed [VW-1:0] rho;
    logic signed [VW-1:0] u;
    logic signed [VW-1:0] m;
    logic signed [VW-1:0] e;
    logic signed [VW-1:0] p;
    logic signed [VW-1:0] pg;
    logic signed [VW-1:0] mu;
    logic signed [VW-1:0] d;
    logic signed [VW-1:0] r1;
    logic signed [VW-1:0] ep;
    logic                 sat;
    logic                 err;
  } pipe_t;

  // Configuration register
  logic [eflux_pkg::GM1_W-1:0] gm1;
  logic signed [VW-1:0]        gm1_s;

  assign pready = 1'b1;
  assign gm1_s  = VW'(gm1);
  assign prdata = (paddr == eflux_pkg::ADDR_GM1) ? 32'(gm1) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gm1 <= eflux_pkg::GM1_RESET;
    end else if (psel && penable && pwrite && paddr == eflux_pkg::ADDR_GM1) begin
      gm1 <= pwdata[eflux_pkg::GM1_W-1:0];
    end
  end

  // Global advance: stall only when the last stage holds a result and the queue is full
  logic en;
  logic ob_full;
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9;

  assign en       = !v9 || !ob_full;
  assign in_ready = en;

  // Divider operands: p / (gamma-1) or m / rho
  logic                 in_odd;
  logic signed [VW-1:0] div_a;
  logic [VW-1:0]        div_b;
  eflux_pkg::ctx_t      in_ctx;

  always_comb begin
    in_odd      = in_data.req_type == eflux_pkg::REQ_FLUX_CONS ||
                  in_data.req_type == eflux_pkg::REQ_CONS_TO_PRIM;
    in_ctx.kind = in_data.req_type;
    in_ctx.rho  = VW'({1'b0, in_data.density});
    in_ctx.v2   = in_data.second_value;
    in_ctx.v3   = in_data.third_value;
    div_a       = in_odd ? in_data.second_value : in_data.third_value;
    div_b       = in_odd ? VW'({1'b0, in_data.density}) : VW'(gm1);
  end

  logic                 d_valid;
  logic signed [VW-1:0] d_q;
  logic                 d_sat;
  eflux_pkg::ctx_t      d_ctx;

  eflux_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .a         (div_a),
    .b         (div_b),
    .in_ctx    (in_ctx),
    .out_valid (d_valid),
    .q         (d_q),
    .sat       (d_sat),
    .out_ctx   (d_ctx)
  );

  pipe_t st1, st2, st3, st4, st5, st6, st7, st8, st9;
  pipe_t st1_next, st2_next, st4_next, st5_next, st7_next, st8_next;
  logic  d_odd;

  logic [2*VW-1:0] p1_prod, p2_prod, p3_prod, p4_prod;
  logic            p1_neg, p2_neg, p3_neg, p4_neg;

  // Stage 1: unpack the request around the quotient, start rho*u
  always_comb begin
    d_odd = d_ctx.kind == eflux_pkg::REQ_FLUX_CONS ||
            d_ctx.kind == eflux_pkg::REQ_CONS_TO_PRIM;
    st1_next      = '0;
    st1_next.kind = d_ctx.kind;
    st1_next.rho  = d_ctx.rho;
    st1_next.err  = d_ctx.rho == '0;
    st1_next.sat  = d_sat;
    if (d_odd) begin
      st1_next.m = d_ctx.v2;
      st1_next.e = d_ctx.v3;
      st1_next.u = d_q;
    end else begin
      st1_next.u  = d_ctx.v2;
      st1_next.p  = d_ctx.v3;
      st1_next.pg = d_q;
    end
  end

  eflux_mul u_mul_rho_u (
    .clk (clk), .en (en), .a (d_ctx.rho), .b (d_ctx.v2),
    .prod (p1_prod), .neg (p1_neg)
  );

  // Stage 2: momentum from primitives
  logic  s2_odd;
  eflux_pkg::sval_t s2_r;
  always_comb begin
    s2_odd   = st1.kind == eflux_pkg::REQ_FLUX_CONS ||
               st1.kind == eflux_pkg::REQ_CONS_TO_PRIM;
    s2_r     = eflux_pkg::rnd_sat(p1_neg, p1_prod);
    st2_next = st1;
    if (!s2_odd) begin
      st2_next.m   = s2_r.val;
      st2_next.sat = st1.sat || s2_r.sat;
    end
  end

  // Stage 3: m*u
  eflux_mul u_mul_m_u (
    .clk (clk), .en (en), .a (st2.m), .b (st2.u),
    .prod (p2_prod), .neg (p2_neg)
  );

  // Stage 4: round m*u
  eflux_pkg::sval_t s4_r;
  always_comb begin
    s4_r         = eflux_pkg::rnd_sat(p2_neg, p2_prod);
    st4_next     = st3;
    st4_next.mu  = s4_r.val;
    st4_next.sat = st3.sat || s4_r.sat;
  end

  // Stage 5: energy from primitives, or E - 0.5*m*u from conservatives
  logic                 s5_odd;
  logic signed [VW-1:0] s5_h;
  eflux_pkg::sval_t     s5_r;
  always_comb begin
    s5_odd   = st4.kind == eflux_pkg::REQ_FLUX_CONS ||
               st4.kind == eflux_pkg::REQ_CONS_TO_PRIM;
    s5_h     = eflux_pkg::half_q(st4.mu);
    st5_next = st4;
    if (s5_odd) begin
      s5_r       = eflux_pkg::sub_sat(st4.e, s5_h);
      st5_next.d = s5_r.val;
    end else begin
      s5_r       = eflux_pkg::add_sat(s5_h, st4.pg);
      st5_next.e = s5_r.val;
    end
    st5_next.sat = st4.sat || s5_r.sat;
  end

  // Stage 6: (gamma-1) * (E - 0.5*m*u)
  eflux_mul u_mul_gm1 (
    .clk (clk), .en (en), .a (gm1_s), .b (st5.d),
    .prod (p3_prod), .neg (p3_neg)
  );

  // Stage 7: pressure from conservatives
  logic             s7_odd;
  eflux_pkg::sval_t s7_r;
  always_comb begin
    s7_odd   = st6.kind == eflux_pkg::REQ_FLUX_CONS ||
               st6.kind == eflux_pkg::REQ_CONS_TO_PRIM;
    s7_r     = eflux_pkg::rnd_sat(p3_neg, p3_prod);
    st7_next = st6;
    if (s7_odd) begin
      st7_next.p   = s7_r.val;
      st7_next.sat = st6.sat || s7_r.sat;
    end
  end

  // Stage 8: momentum flux and E + p; these count only for flux requests
  logic             s8_flux;
  eflux_pkg::sval_t s8_a, s8_b;
  always_comb begin
    s8_flux  = st7.kind == eflux_pkg::REQ_FLUX_PRIM ||
               st7.kind == eflux_pkg::REQ_FLUX_CONS;
    s8_a     = eflux_pkg::add_sat(st7.p, st7.mu);
    s8_b     = eflux_pkg::add_sat(st7.e, st7.p);
    st8_next     = st7;
    st8_next.r1  = s8_a.val;
    st8_next.ep  = s8_b.val;
    st8_next.sat = st7.sat || (s8_flux && (s8_a.sat || s8_b.sat));
  end

  // Stage 9: u*(E+p)
  eflux_mul u_mul_u_ep (
    .clk (clk), .en (en), .a (st8.u), .b (st8.ep),
    .prod (p4_prod), .neg (p4_neg)
  );

  // Final: select the result by kind and build the status
  eflux_pkg::sval_t     s10_r;
  eflux_pkg::out_item_t res;
  logic                 res_sat;
  always_comb begin
    s10_r   = eflux_pkg::rnd_sat(p4_neg, p4_prod);
    res_sat = st9.sat;
    unique case (st9.kind)
      eflux_pkg::REQ_FLUX_PRIM, eflux_pkg::REQ_FLUX_CONS: begin
        res.out_first  = st9.m;
        res.out_second = st9.r1;
        res.out_third  = s10_r.val;
        res_sat        = st9.sat || s10_r.sat;
      end
      eflux_pkg::REQ_PRIM_TO_CONS: begin
        res.out_first  = st9.rho;
        res.out_second = st9.m;
        res.out_third  = st9.e;
      end
      default: begin
        res.out_first  = st9.rho;
        res.out_second = st9.u;
        res.out_third  = st9.p;
      end
    endcase
    res.status = res_sat ? eflux_pkg::ST_SAT : eflux_pkg::ST_OK;
    if (st9.err) begin
      res.out_first  = '0;
      res.out_second = '0;
      res.out_third  = '0;
      res.status     = eflux_pkg::ST_DENSITY;
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9} <= '0;
    end else if (en) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9} <= {d_valid, v1, v2, v3, v4, v5, v6, v7, v8};
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      st1 <= st1_next;
      st2 <= st2_next;
      st3 <= st2;
      st4 <= st4_next;
      st5 <= st5_next;
      st6 <= st5;
      st7 <= st7_next;
      st8 <= st8_next;
      st9 <= st8;
    end
  end

  eflux_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (v9 && en),
    .push_data (res),
    .full      (ob_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A density error always comes with zero values
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == eflux_pkg::ST_DENSITY |->
      out_data.out_first == '0 && out_data.out_second == '0 && out_data.out_third == '0)
    else $error("density error with nonzero values");

  // Input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && v9)
    else $error("input stalled without a pending result");

  // Status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status == eflux_pkg::ST_OK ||
                  out_data.status == eflux_pkg::ST_DENSITY ||
                  out_data.status == eflux_pkg::ST_SAT)
    else $error("undefined status code");

endmodule
